>>> design/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, status codes and alphabet functions of the base64url codec.
// ----------------------------------------------------------------------------
`default_nettype none

package b64_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_BAD_PAD  = 2'd2
  } b64_status_e;

  localparam logic [7:0] PadChar = 8'h3D;

  typedef struct packed {
    logic [7:0]  data;
    logic        valid;
    b64_status_e status;
    logic        last;
  } b64_res_t;

  typedef struct packed {
    logic [1:0] cnt;
    b64_res_t   r0;
    b64_res_t   r1;
  } b64_push_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    case (v) inside
      [6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
      [6'd26:6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
      [6'd52:6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
      6'd62:         c = 8'h2D;
      default:       c = 8'h5F;
    endcase
    return c;
  endfunction

  // Bit 6 flags a character of the alphabet, bits 5:0 carry its value.
  function automatic logic [6:0] dec_value(input logic [7:0] c);
    logic [7:0] t;
    logic [6:0] r;
    t = 8'h00;
    case (c) inside
      [8'h41:8'h5A]: begin
        t = c - 8'h41;
        r = {1'b1, t[5:0]};
      end
      [8'h61:8'h7A]: begin
        t = c - 8'h61 + 8'd26;
        r = {1'b1, t[5:0]};
      end
      [8'h30:8'h39]: begin
        t = c - 8'h30 + 8'd52;
        r = {1'b1, t[5:0]};
      end
      8'h2D:   r = {1'b1, 6'd62};
      8'h5F:   r = {1'b1, 6'd63};
      default: r = {1'b0, t[5:0]};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/b64_core.sv
// ----------------------------------------------------------------------------
// b64_core
// Mode register, bit residue and error state, and the per-item step logic.
// ----------------------------------------------------------------------------
`default_nettype none

module b64_core (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               mode_we_i,
  input  wire               mode_i,
  input  wire               step_i,
  input  wire  [7:0]        data_i,
  input  wire               last_i,
  output b64_pkg::b64_push_t push_o
);
  import b64_pkg::*;

  logic        mode_q;
  logic [5:0]  res_q, res_d;
  logic [2:0]  rcnt_q, rcnt_d;
  logic [1:0]  pad_q, pad_d;
  b64_status_e err_q, err_d;
  b64_push_t   push;

  logic [5:0]  c0, c1;
  logic [6:0]  dv;

  always_comb begin
    res_d  = res_q;
    rcnt_d = rcnt_q;
    pad_d  = pad_q;
    err_d  = err_q;
    push   = '0;
    c0     = '0;
    c1     = '0;
    dv     = dec_value(data_i);
    if (!mode_q) begin
      case (rcnt_q)
        3'd0: begin
          c0       = data_i[7:2];
          res_d    = {4'b0000, data_i[1:0]};
          rcnt_d   = 3'd2;
          push.cnt = 2'd1;
        end
        3'd2: begin
          c0       = {res_q[1:0], data_i[7:4]};
          res_d    = {2'b00, data_i[3:0]};
          rcnt_d   = 3'd4;
          push.cnt = 2'd1;
        end
        default: begin
          c0       = {res_q[3:0], data_i[7:6]};
          c1       = data_i[5:0];
          res_d    = '0;
          rcnt_d   = 3'd0;
          push.cnt = 2'd2;
        end
      endcase
      if (last_i) begin
        if (rcnt_d == 3'd2) begin
          c1 = {res_d[1:0], 4'b0000};
        end else if (rcnt_d == 3'd4) begin
          c1 = {res_d[3:0], 2'b00};
        end
        push.cnt = 2'd2;
      end
      push.r0 = '{data: enc_char(c0), valid: 1'b1, status: ST_OK, last: 1'b0};
      push.r1 = '{data: enc_char(c1), valid: 1'b1, status: ST_OK, last: last_i};
    end else if (err_q != ST_OK) begin
      if (last_i) begin
        push.cnt = 2'd1;
        push.r0  = '{data: 8'h00, valid: 1'b0, status: err_q, last: 1'b1};
      end
    end else begin
      if (data_i == PadChar) begin
        if (pad_q >= 2'd2) begin
          err_d = ST_BAD_PAD;
        end else begin
          pad_d = pad_q + 2'd1;
        end
      end else if (pad_q != 2'd0) begin
        err_d = ST_BAD_PAD;
      end else if (!dv[6]) begin
        err_d = ST_BAD_CHAR;
      end else begin
        case (rcnt_q)
          3'd0: begin
            res_d  = dv[5:0];
            rcnt_d = 3'd6;
          end
          3'd2: begin
            push.cnt     = 2'd1;
            push.r0.data = {res_q[1:0], dv[5:0]};
            res_d        = '0;
            rcnt_d       = 3'd0;
          end
          3'd4: begin
            push.cnt     = 2'd1;
            push.r0.data = {res_q[3:0], dv[5:2]};
            res_d        = {4'b0000, dv[1:0]};
            rcnt_d       = 3'd2;
          end
          default: begin
            push.cnt     = 2'd1;
            push.r0.data = {res_q[5:0], dv[5:4]};
            res_d        = {2'b00, dv[3:0]};
            rcnt_d       = 3'd4;
          end
        endcase
        push.r0.valid  = (push.cnt != 2'd0);
        push.r0.status = ST_OK;
        push.r0.last   = last_i;
      end
      if (err_d != ST_OK) begin
        push.cnt = 2'd1;
        push.r0  = '{data: 8'h00, valid: 1'b0, status: err_d, last: last_i};
      end else if (last_i && push.cnt == 2'd0) begin
        push.cnt = 2'd1;
        push.r0  = '{data: 8'h00, valid: 1'b0, status: ST_OK, last: 1'b1};
      end
    end
    if (last_i) begin
      res_d  = '0;
      rcnt_d = '0;
      pad_d  = '0;
      err_d  = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      res_q  <= '0;
      rcnt_q <= '0;
      pad_q  <= '0;
      err_q  <= ST_OK;
    end else if (mode_we_i) begin
      mode_q <= mode_i;
      res_q  <= '0;
      rcnt_q <= '0;
      pad_q  <= '0;
      err_q  <= ST_OK;
    end else if (step_i) begin
      res_q  <= res_d;
      rcnt_q <= rcnt_d;
      pad_q  <= pad_d;
      err_q  <= err_d;
    end
  end

  assign push_o = step_i ? push : '0;

  a_enc_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !mode_q) |-> (push_o.cnt != 2'd0))
    else $error("encode step produced no character");

  a_last_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_i) |-> (push_o.cnt != 2'd0))
    else $error("last element produced no result");

  a_enc_residue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mode_q |-> (rcnt_q == 3'd0 || rcnt_q == 3'd2 || rcnt_q == 3'd4))
    else $error("encode residue count out of range");

endmodule

`default_nettype wire

>>> design/b64_res_fifo.sv
// ----------------------------------------------------------------------------
// b64_res_fifo
// Four-entry result queue that takes up to two results a cycle and hands
// out one result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module b64_res_fifo (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  b64_pkg::b64_push_t push_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output b64_pkg::b64_res_t  out_o
);
  import b64_pkg::*;

  b64_res_t    mem_q [4];
  logic [1:0]  wr_ptr_q, wr_ptr_d;
  logic [1:0]  rd_ptr_q, rd_ptr_d;
  logic [2:0]  count_q, count_d;
  logic        pop;
  logic [1:0]  wr_ptr_p1;

  assign pop       = (count_q != 3'd0) && !out_stall_i;
  assign wr_ptr_p1 = wr_ptr_q + 2'd1;
  assign wr_ptr_d  = wr_ptr_q + push_i.cnt;
  assign rd_ptr_d  = rd_ptr_q + {1'b0, pop};
  assign count_d   = count_q + {1'b0, push_i.cnt} - {2'b00, pop};

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_p1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign room_o      = (count_q <= 3'd2);
  assign out_valid_o = (count_q != 3'd0);
  assign out_o       = mem_q[rd_ptr_q];

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> (count_q <= 3'd2))
    else $error("result queue written without room");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'd4)
    else $error("result queue count out of range");

  a_ptr_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[1:0])
    else $error("result queue pointers disagree with count");

endmodule

`default_nettype wire

>>> design/base64url_stream_codec_unit.sv
// ----------------------------------------------------------------------------
// base64url_stream_codec_unit
// Streaming URL-safe base64 encoder and decoder.
//
// Input items (data_in_i, last_in_i) arrive on a valid and stall channel and
// results leave on a second one; a transfer occurs when valid is high and
// stall is low. mode_we_i writes mode_i (0 encode, 1 decode) and clears the
// message state; the user must write it only while the block is idle, which
// the block itself does not enforce. An accepted item lands in an input
// register, is processed once the result queue has room, and its results
// enter a four-entry result queue, from which they are offered. Encoding
// yields one or two characters per byte, decoding at most one result per
// character.
// One item is taken per cycle while the queue holds at most two results, so
// throughput is set by the output side: one result per cycle unless stalled.
// When the receiver stalls, results wait in the queue and the input register
// holds its item, which raises in_stall_o once the queue is too full.
// Reset empties the queue and input register and sets encode mode.
// ----------------------------------------------------------------------------
`default_nettype none

module base64url_stream_codec_unit (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        mode_we_i,
  input  wire        mode_i,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire  [7:0] data_in_i,
  input  wire        last_in_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [7:0] data_out_o,
  output logic       data_valid_o,
  output logic [1:0] status_o,
  output logic       last_out_o
);
  import b64_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_data_q;
  logic       in_last_q;
  logic       room;
  logic       step;
  logic       accept;
  b64_push_t  push;
  b64_res_t   res;

  assign step       = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_vld_d   = accept ? 1'b1 : (step ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q <= data_in_i;
      in_last_q <= last_in_i;
    end
  end

  b64_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_we_i (mode_we_i),
    .mode_i    (mode_i),
    .step_i    (step),
    .data_i    (in_data_q),
    .last_i    (in_last_q),
    .push_o    (push)
  );

  b64_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res)
  );

  assign data_out_o   = res.data;
  assign data_valid_o = res.valid;
  assign status_o     = res.status;
  assign last_out_o   = res.last;

endmodule

`default_nettype wire

>>> test/base64url_stream_codec_unit_test.sv
// ----------------------------------------------------------------------------
// base64url_stream_codec_unit_test
// Self-checking testbench for the streaming base64url encoder and decoder.
//
// A directed set of messages covers edge bytes, padding rules, alphabet
// faults, fault swallowing and a mode write in the middle of a message.
// Random phases follow, each in one mode, mostly with well-formed messages
// and some broken ones. A small scoreboard predicts every result of each
// accepted transfer and compares the results in order. Both channels idle
// and stall at random.
// ----------------------------------------------------------------------------

module base64url_stream_codec_unit_test;

  import b64_pkg::*;

  class codec_scoreboard;
    bit          dec_mode;
    logic [7:0]  residue;
    int          nbits;
    int          pads;
    b64_status_e fault;
    b64_res_t    expected_q[$];
    int          errors;
    int          inputs;
    int          outputs;
    int          swallowed;
    int          bad_chars;
    int          bad_pads;

    function new();
      dec_mode = 1'b0;
      clear_msg();
    endfunction

    static function logic [7:0] alpha_char(logic [5:0] v);
      string abc;
      abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
      return abc[v];
    endfunction

    static function int char_val(logic [7:0] c);
      for (int i = 0; i < 64; i++) begin
        if (alpha_char(6'(i)) == c) return i;
      end
      return -1;
    endfunction

    function void clear_msg();
      residue = 8'h00;
      nbits = 0;
      pads = 0;
      fault = ST_OK;
    endfunction

    function void set_mode(bit m);
      dec_mode = m;
      clear_msg();
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push(logic [7:0] d, logic v, b64_status_e s, logic l);
      b64_res_t r;
      r.data = d;
      r.valid = v;
      r.status = s;
      r.last = l;
      expected_q.insert(expected_q.size(), r);
      if (s == ST_BAD_CHAR) bad_chars++;
      if (s == ST_BAD_PAD) bad_pads++;
    endfunction

    function void encode_byte(logic [7:0] d, logic l);
      logic [15:0] acc;
      logic [5:0]  six;
      logic [7:0]  chars [2];
      int          n;
      int          cnt;
      n = 0;
      cnt = nbits;
      acc = ((({8'h00, residue} & ((16'h1 << cnt) - 16'h1))) << 8) | {8'h00, d};
      cnt += 8;
      while (cnt >= 6) begin
        cnt -= 6;
        six = 6'(acc >> cnt);
        chars[n] = alpha_char(six);
        n++;
      end
      acc = acc & ((16'h1 << cnt) - 16'h1);
      if (l && cnt > 0) begin
        six = 6'(acc << (6 - cnt));
        chars[n] = alpha_char(six);
        n++;
        cnt = 0;
        acc = 16'h0;
      end
      residue = acc[7:0];
      nbits = cnt;
      for (int i = 0; i < n; i++) begin
        push(chars[i], 1'b1, ST_OK, l && (i == n - 1));
      end
      if (l) clear_msg();
    endfunction

    function void decode_char(logic [7:0] c, logic l);
      logic [15:0] acc;
      int          v;
      int          cnt;
      bit          got_byte;
      got_byte = 1'b0;
      if (fault != ST_OK) begin
        if (l) begin
          push(8'h00, 1'b0, fault, 1'b1);
          clear_msg();
        end else begin
          swallowed++;
        end
        return;
      end
      if (c == PadChar) begin
        if (pads >= 2) fault = ST_BAD_PAD;
        else pads++;
      end else if (pads != 0) begin
        fault = ST_BAD_PAD;
      end else begin
        v = char_val(c);
        if (v < 0) begin
          fault = ST_BAD_CHAR;
        end else begin
          cnt = nbits;
          acc = (({8'h00, residue} & ((16'h1 << cnt) - 16'h1)) << 6) | 16'(v);
          cnt += 6;
          if (cnt >= 8) begin
            cnt -= 8;
            push(8'(acc >> cnt), 1'b1, ST_OK, l);
            got_byte = 1'b1;
          end
          residue = 8'(acc & ((16'h1 << cnt) - 16'h1));
          nbits = cnt;
        end
      end
      if (fault != ST_OK) push(8'h00, 1'b0, fault, l);
      else if (l && !got_byte) push(8'h00, 1'b0, ST_OK, 1'b1);
      if (l) clear_msg();
    endfunction

    function void note_input(logic [7:0] d, logic l);
      inputs++;
      if (dec_mode) decode_char(d, l);
      else encode_byte(d, l);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", what);
    endtask

    task check_result(logic [7:0] d, logic v, logic [1:0] s, logic l);
      b64_res_t e;
      outputs++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result data=%02h valid=%0b status=%0d last=%0b",
                         d, v, s, l));
      end else begin
        e = expected_q.pop_front();
        if (d !== e.data || v !== e.valid || s !== e.status || l !== e.last) begin
          report($sformatf("got data=%02h valid=%0b status=%0d last=%0b, want %02h %0b %0d %0b",
                           d, v, s, l, e.data, e.valid, e.status, e.last));
        end
      end
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       mode_we_i;
  logic       mode_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_in_i;
  logic       last_in_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] data_out_o;
  logic       data_valid_o;
  logic [1:0] status_o;
  logic       last_out_o;

  codec_scoreboard sb;
  logic [7:0]      msg_q[$];
  bit              calm_in;
  bit              calm_out;
  int              messages;
  int              mode_writes;

  base64url_stream_codec_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_we_i    (mode_we_i),
    .mode_i       (mode_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_in_i    (data_in_i),
    .last_in_i    (last_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_out_o   (data_out_o),
    .data_valid_o (data_valid_o),
    .status_o     (status_o),
    .last_out_o   (last_out_o)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(data_out_o, data_valid_o, status_o, last_out_o);
      end
      if (in_valid_i && !in_stall_o) sb.note_input(data_in_i, last_in_i);
    end
  end

  function int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  initial begin
    int n;
    out_stall_i = 1'b0;
    calm_out = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 49) == 0) calm_out = !calm_out;
      if (calm_out) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        n = rand_gap();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  task send_item(logic [7:0] d, logic l);
    int gap;
    gap = calm_in ? 0 : rand_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_in_i <= d;
    last_in_i <= l;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task send_msg(bit finish);
    for (int i = 0; i < msg_q.size(); i++) begin
      send_item(msg_q[i], finish && (i == msg_q.size() - 1));
    end
    if (finish) messages++;
  endtask

  // The sender holds off until every predicted result has been checked.
  task drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task write_mode(bit m);
    drain();
    mode_i <= m;
    mode_we_i <= 1'b1;
    @(posedge clk_i);
    sb.set_mode(m);
    mode_we_i <= 1'b0;
    mode_writes++;
  endtask

  task load_text(string s);
    msg_q.delete();
    for (int i = 0; i < s.len(); i++) msg_q.insert(msg_q.size(), s[i]);
  endtask

  task gen_encode();
    int len;
    msg_q.delete();
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
    repeat (len) msg_q.insert(msg_q.size(), 8'($urandom_range(0, 255)));
  endtask

  task gen_decode();
    int len;
    int kind;
    msg_q.delete();
    len = $urandom_range(1, 10);
    repeat (len) begin
      msg_q.insert(msg_q.size(), codec_scoreboard::alpha_char(6'($urandom_range(0, 63))));
    end
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 2)) msg_q.insert(msg_q.size(), PadChar);
      end
    end else if (kind == 6) begin
      msg_q.insert($urandom_range(0, len), 8'($urandom_range(0, 255)));
    end else if (kind == 7) begin
      msg_q.insert($urandom_range(0, len - 1), PadChar);
    end else if (kind == 8) begin
      repeat ($urandom_range(3, 4)) msg_q.insert(msg_q.size(), PadChar);
    end else begin
      msg_q.delete();
      msg_q.insert(msg_q.size(), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    bit m;
    sb = new();
    rst_ni = 1'b0;
    mode_we_i = 1'b0;
    mode_i = 1'b0;
    in_valid_i = 1'b0;
    data_in_i = 8'h00;
    last_in_i = 1'b0;
    calm_in = 1'b0;
    messages = 0;
    mode_writes = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_mode(1'b0);
    msg_q = '{8'h00};
    send_msg(1'b1);
    msg_q = '{8'hFF, 8'hFF, 8'hFF};
    send_msg(1'b1);
    msg_q = '{8'h80, 8'h01};
    send_msg(1'b1);
    msg_q = '{8'h12, 8'h34};
    send_msg(1'b0);
    write_mode(1'b0);
    msg_q = '{8'hA5};
    send_msg(1'b1);

    write_mode(1'b1);
    load_text("AA==");
    send_msg(1'b1);
    load_text("-_");
    send_msg(1'b1);
    load_text("Az=x");
    send_msg(1'b1);
    load_text("!");
    send_msg(1'b1);
    load_text("A===");
    send_msg(1'b1);
    load_text("A");
    send_msg(1'b1);
    msg_q = '{8'hFF};
    send_msg(1'b1);
    load_text("A!z");
    send_msg(1'b0);
    write_mode(1'b1);

    while (sb.inputs < 920) begin
      m = 1'($urandom_range(0, 1));
      write_mode(m);
      calm_in = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 12)) begin
        if (m) gen_decode();
        else gen_encode();
        send_msg($urandom_range(0, 19) != 0);
        if ($urandom_range(0, 9) == 0) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d input and %0d result transfers in %0d messages, %0d mode writes.",
             sb.inputs, sb.outputs, messages, mode_writes);
    $display("Decode faults seen: %0d outside the alphabet, %0d bad padding.",
             sb.bad_chars, sb.bad_pads);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(12 * 2000000);
    $display("Timeout with %0d results still expected.", sb.pending());
    $display("TB_ERROR");
    $finish;
  end

endmodule
